>>> sv/drive_fault_stop_restart_arbiter_top_defines.svh
// Assertion macros used by the arbiter top module.
`ifndef DRIVE_FAULT_STOP_RESTART_ARBITER_TOP_DEFINES_SVH
`define DRIVE_FAULT_STOP_RESTART_ARBITER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DFSRA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dfsra assertion failed");

// Next-cycle implication, checked outside reset.
`define DFSRA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dfsra assertion failed");

`endif

>>> sv/dfsra_pkg.sv
// ----------------------------------------------------------------------------
// dfsra_pkg
// Types and constants for the drive fault stop / restart arbiter.
// ----------------------------------------------------------------------------
package dfsra_pkg;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int SLOT_W        = 6;
    localparam int MAP_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam logic [31:0] TIME_NONE = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        DS_RUN      = 2'd0,
        DS_STOPPING = 2'd1,
        DS_STOPPED  = 2'd2
    } drive_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STOP_MASK    = 3'd0,
        CFG_START_MASK   = 3'd1,
        CFG_WAIT_MASK    = 3'd2,
        CFG_IDLE_REQUEST = 3'd3,
        CFG_STOP_BRAKE   = 3'd4,
        CFG_AUTO_RESTART = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [15:0]        stop_mask;
        logic [15:0]        start_mask;
        logic [15:0]        wait_mask;
        logic [15:0]        idle_request_code;
        logic signed [15:0] stop_brake_code;
        logic               auto_restart_enable;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         drive_state;
        logic               second_tick;
        logic               slot_fault;
        logic [15:0]        slot_request;
        logic signed [31:0] slot_time;
        logic signed [15:0] slot_brake_type;
        logic               last_slot;
    } item_t;

    typedef struct packed {
        logic signed [15:0] brake_type_out;
        logic [SLOT_W-1:0]  first_fault_slot;
        logic [SLOT_W-1:0]  start_slot_out;
        logic [SLOT_W-1:0]  stop_slot_out;
        logic [MAP_W-1:0]   fault_bitmap;
        logic signed [31:0] min_trip_time;
        logic signed [31:0] restart_delay_out;
    } result_t;

endpackage

>>> sv/drive_fault_stop_restart_arbiter_top.sv
// A closing slot item is held in the input register; m_valid rises when it advances to the result register.
// Throughput: one slot item per cycle unless stalled; the scan state update is a single registered pass.
// The input register stalls only when it holds a closing item, the result register is full
// and m_ready is low.
// Reset (aresetn low, synchronous): config registers to defaults, scan state cleared,
// countdown and stored slots zero, both valid flags low.
// ----------------------------------------------------------------------------
// drive_fault_stop_restart_arbiter_top
// Fault slot scanner with stop/start arbitration and auto-restart countdown.
// ----------------------------------------------------------------------------
`include "drive_fault_stop_restart_arbiter_top_defines.svh"

module drive_fault_stop_restart_arbiter_top #(
    parameter int MAX_SLOTS = dfsra_pkg::MAX_SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dfsra_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_drive_state,
    input  logic                              s_second_tick,
    input  logic                              s_slot_fault,
    input  logic [15:0]                       s_slot_request,
    input  logic signed [31:0]                s_slot_time,
    input  logic signed [15:0]                s_slot_brake_type,
    input  logic                              s_last_slot,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [15:0]                m_brake_type_out,
    output logic [dfsra_pkg::SLOT_W-1:0]      m_first_fault_slot,
    output logic [dfsra_pkg::SLOT_W-1:0]      m_start_slot_out,
    output logic [dfsra_pkg::SLOT_W-1:0]      m_stop_slot_out,
    output logic [dfsra_pkg::MAP_W-1:0]       m_fault_bitmap,
    output logic signed [31:0]                m_min_trip_time,
    output logic signed [31:0]                m_restart_delay_out
);
    import dfsra_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    m_valid_reg;
    result_t result;
    logic    advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stop_mask           <= 16'd1;
            cfg_reg.start_mask          <= 16'd2;
            cfg_reg.wait_mask           <= 16'd4;
            cfg_reg.idle_request_code   <= '0;
            cfg_reg.stop_brake_code     <= '0;
            cfg_reg.auto_restart_enable <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_STOP_MASK:    cfg_reg.stop_mask           <= cfg_data;
                CFG_START_MASK:   cfg_reg.start_mask          <= cfg_data;
                CFG_WAIT_MASK:    cfg_reg.wait_mask           <= cfg_data;
                CFG_IDLE_REQUEST: cfg_reg.idle_request_code   <= cfg_data;
                CFG_STOP_BRAKE:   cfg_reg.stop_brake_code     <= $signed(cfg_data);
                CFG_AUTO_RESTART: cfg_reg.auto_restart_enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // only a closing item needs room in the result register
    assign advance = in_valid_reg && (!item_reg.last_slot || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.drive_state     <= s_drive_state;
            item_reg.second_tick     <= s_second_tick;
            item_reg.slot_fault      <= s_slot_fault;
            item_reg.slot_request    <= s_slot_request;
            item_reg.slot_time       <= s_slot_time;
            item_reg.slot_brake_type <= s_slot_brake_type;
            item_reg.last_slot       <= s_last_slot;
        end
    end

    dfsra_scan #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .advance (advance),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && item_reg.last_slot) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item_reg.last_slot) begin
            out_reg <= result;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_brake_type_out    = out_reg.brake_type_out;
    assign m_first_fault_slot  = out_reg.first_fault_slot;
    assign m_start_slot_out    = out_reg.start_slot_out;
    assign m_stop_slot_out     = out_reg.stop_slot_out;
    assign m_fault_bitmap      = out_reg.fault_bitmap;
    assign m_min_trip_time     = out_reg.min_trip_time;
    assign m_restart_delay_out = out_reg.restart_delay_out;

    `DFSRA_ASSERT_IMP(a_result_from_close, aclk, aresetn, $rose(m_valid_reg), $past(advance && item_reg.last_slot))
    `DFSRA_ASSERT_IMP(a_close_stalls, aclk, aresetn, in_valid_reg && item_reg.last_slot && m_valid_reg && !m_ready, !s_ready)
    `DFSRA_ASSERT_IMP(a_slot0_clear, aclk, aresetn, m_valid_reg, !out_reg.fault_bitmap[0])
    `DFSRA_ASSERT_IMP(a_first_in_map, aclk, aresetn, m_valid_reg && (out_reg.first_fault_slot != '0), out_reg.fault_bitmap[out_reg.first_fault_slot])

endmodule

>>> sv/dfsra_scan.sv
// ----------------------------------------------------------------------------
// dfsra_scan
// Per-slot scan state, stop/start arbitration and restart countdown.
// ----------------------------------------------------------------------------
module dfsra_scan #(
    parameter int MAX_SLOTS = dfsra_pkg::MAX_SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dfsra_pkg::cfg_t   cfg,
    input  dfsra_pkg::item_t  item,
    input  logic              advance,
    output dfsra_pkg::result_t result
);
    import dfsra_pkg::*;

    localparam int POS_W = $clog2(MAX_SLOTS + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SLOTS);

    logic [31:0]        restart_delay_reg, restart_delay_next;
    logic [15:0]        saved_request_reg, saved_request_next;
    logic [SLOT_W-1:0]  saved_stop_slot_reg, saved_stop_slot_next;
    logic [SLOT_W-1:0]  saved_start_slot_reg, saved_start_slot_next;
    logic [POS_W-1:0]   scan_position_reg, scan_position_next;
    logic [MAP_W-1:0]   scan_fault_bits_reg, scan_fault_bits_next;
    logic [31:0]        scan_min_time_reg, scan_min_time_next;
    logic [SLOT_W-1:0]  scan_first_fault_reg, scan_first_fault_next;
    logic [SLOT_W-1:0]  scan_stop_found_reg, scan_stop_found_next;
    logic [SLOT_W-1:0]  scan_start_found_reg, scan_start_found_next;
    logic [15:0]        scan_brake_type_reg, scan_brake_type_next;
    logic               stop_fault_reg, stop_fault_next;

    logic               in_range;
    logic [SLOT_W-1:0]  slot;
    logic               hold_countdown;

    assign in_range = scan_position_reg < POS_MAX;
    assign slot     = SLOT_W'(scan_position_reg);

    always_comb begin
        restart_delay_next    = restart_delay_reg;
        saved_request_next    = saved_request_reg;
        saved_stop_slot_next  = saved_stop_slot_reg;
        saved_start_slot_next = saved_start_slot_reg;
        scan_position_next    = scan_position_reg;
        scan_fault_bits_next  = scan_fault_bits_reg;
        scan_min_time_next    = scan_min_time_reg;
        scan_first_fault_next = scan_first_fault_reg;
        scan_stop_found_next  = scan_stop_found_reg;
        scan_start_found_next = scan_start_found_reg;
        scan_brake_type_next  = scan_brake_type_reg;
        stop_fault_next       = stop_fault_reg;
        hold_countdown        = 1'b0;

        if (in_range) begin
            if (slot == '0) begin
                stop_fault_next = 1'b0;
            end
            // fault flag of the stored stop slot gates the countdown
            if (slot == saved_stop_slot_reg) begin
                stop_fault_next = item.slot_fault;
            end
            if (slot != '0) begin
                if (item.slot_fault) begin
                    scan_fault_bits_next[slot] = 1'b1;
                    if (scan_first_fault_reg == '0) begin
                        scan_first_fault_next = slot;
                    end
                end
                case (item.drive_state)
                    DS_RUN: begin
                        if ($signed(item.slot_time) < $signed(scan_min_time_reg)) begin
                            scan_min_time_next = item.slot_time;
                        end
                        if (((item.slot_request & cfg.stop_mask) != '0) &&
                            (scan_stop_found_reg == '0)) begin
                            scan_brake_type_next  = item.slot_brake_type;
                            scan_stop_found_next  = slot;
                            restart_delay_next    = item.slot_time;
                            saved_request_next    = item.slot_request;
                            saved_stop_slot_next  = slot;
                            saved_start_slot_next = '0;
                        end
                    end
                    DS_STOPPING: begin
                        if (scan_stop_found_reg == '0) begin
                            if ((item.slot_request & cfg.stop_mask) != '0) begin
                                scan_brake_type_next = item.slot_brake_type;
                                if (item.slot_brake_type == cfg.stop_brake_code) begin
                                    scan_stop_found_next  = slot;
                                    restart_delay_next    = item.slot_time;
                                    saved_request_next    = item.slot_request;
                                    saved_stop_slot_next  = slot;
                                    saved_start_slot_next = '0;
                                end
                            end else if ((item.slot_request & cfg.start_mask) != '0) begin
                                scan_start_found_next = slot;
                            end
                        end
                    end
                    default: begin
                        if (((item.slot_request & cfg.start_mask) != '0) &&
                            (scan_start_found_reg == '0)) begin
                            scan_start_found_next = slot;
                        end
                    end
                endcase
            end
            scan_position_next = scan_position_reg + POS_W'(1);
        end

        if (item.last_slot) begin
            hold_countdown = ((saved_request_next & cfg.wait_mask) != '0) && stop_fault_next;
            // drive_state codes 2 and 3 both mean stopped
            if (item.drive_state[1] && cfg.auto_restart_enable && item.second_tick &&
                !hold_countdown) begin
                if ($signed(restart_delay_next) > 0) begin
                    restart_delay_next = restart_delay_next - 32'd1;
                end else begin
                    scan_start_found_next = saved_stop_slot_next;
                end
            end
            if (!cfg.auto_restart_enable || (scan_stop_found_next != '0)) begin
                restart_delay_next    = '0;
                saved_request_next    = cfg.idle_request_code;
                saved_start_slot_next = '0;
            end else if (scan_start_found_next != '0) begin
                restart_delay_next    = '0;
                saved_request_next    = cfg.start_mask;
                saved_stop_slot_next  = '0;
                saved_start_slot_next = scan_start_found_next;
            end
        end

        result.brake_type_out    = $signed(scan_brake_type_next);
        result.first_fault_slot  = scan_first_fault_next;
        result.start_slot_out    = saved_start_slot_next;
        result.stop_slot_out     = saved_stop_slot_next;
        result.fault_bitmap      = scan_fault_bits_next;
        result.min_trip_time     = $signed(scan_min_time_next);
        result.restart_delay_out = $signed(restart_delay_next);

        if (item.last_slot) begin
            scan_position_next    = '0;
            scan_fault_bits_next  = '0;
            scan_min_time_next    = TIME_NONE;
            scan_first_fault_next = '0;
            scan_stop_found_next  = '0;
            scan_start_found_next = '0;
            scan_brake_type_next  = '0;
            stop_fault_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            restart_delay_reg    <= '0;
            saved_request_reg    <= '0;
            saved_stop_slot_reg  <= '0;
            saved_start_slot_reg <= '0;
            scan_position_reg    <= '0;
            scan_fault_bits_reg  <= '0;
            scan_min_time_reg    <= TIME_NONE;
            scan_first_fault_reg <= '0;
            scan_stop_found_reg  <= '0;
            scan_start_found_reg <= '0;
            scan_brake_type_reg  <= '0;
            stop_fault_reg       <= 1'b0;
        end else if (advance) begin
            restart_delay_reg    <= restart_delay_next;
            saved_request_reg    <= saved_request_next;
            saved_stop_slot_reg  <= saved_stop_slot_next;
            saved_start_slot_reg <= saved_start_slot_next;
            scan_position_reg    <= scan_position_next;
            scan_fault_bits_reg  <= scan_fault_bits_next;
            scan_min_time_reg    <= scan_min_time_next;
            scan_first_fault_reg <= scan_first_fault_next;
            scan_stop_found_reg  <= scan_stop_found_next;
            scan_start_found_reg <= scan_start_found_next;
            scan_brake_type_reg  <= scan_brake_type_next;
            stop_fault_reg       <= stop_fault_next;
        end
    end

endmodule
